/* hdl/sbq_pkg.sv */
// shared types, constants and helpers for the stereo biquad cascade
`timescale 1ns / 1ps
package sbq_pkg;
    localparam int BANDS_DEF = 32;
    localparam int SMP_W     = 29;
    localparam int CF_W      = 32;
    localparam int DL_W      = 48;
    localparam int NCOEF     = 5;
    localparam int MQ_W      = 53;
    localparam int SUM_W     = 56;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    localparam logic [2:0] SEL_B0 = 3'd0;
    localparam logic [2:0] SEL_B1 = 3'd1;
    localparam logic [2:0] SEL_B2 = 3'd2;
    localparam logic [2:0] SEL_A1 = 3'd3;
    localparam logic [2:0] SEL_A2 = 3'd4;

    // section schedule steps
    localparam logic [2:0] STP_Y    = 3'd2;
    localparam logic [2:0] STP_ACC1 = 3'd3;
    localparam logic [2:0] STP_ACC2 = 3'd4;
    localparam logic [2:0] STP_Z1   = 3'd5;
    localparam logic [2:0] STP_Z2   = 3'd6;
    localparam logic [2:0] STP_LAST = 3'd7;

    typedef struct packed {
        logic [1:0][NCOEF-1:0][CF_W-1:0] coef;
        logic signed [DL_W-1:0]          zl1;
        logic signed [DL_W-1:0]          zl2;
        logic signed [DL_W-1:0]          zr1;
        logic signed [DL_W-1:0]          zr2;
    } t_rec;

    function automatic logic signed [DL_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DL_W+1){1'b0}}, {(DL_W-1){1'b1}}};
        lo = {{(SUM_W-DL_W+1){1'b1}}, {(DL_W-1){1'b0}}};
        if (v > hi) return hi[DL_W-1:0];
        if (v < lo) return lo[DL_W-1:0];
        return v[DL_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] clamp8(input logic signed [DL_W-1:0] v);
        logic signed [DL_W-1:0] pos;
        logic signed [DL_W-1:0] neg;
        pos = 48'sd134217728;
        neg = -48'sd134217728;
        if (v > pos) return pos[SMP_W-1:0];
        if (v < neg) return neg[SMP_W-1:0];
        return v[SMP_W-1:0];
    endfunction
endpackage

/* hdl/sbq_cell.sv */
// one cell of the band ring: coefficients of both banks and the delay state
`timescale 1ns / 1ps
module sbq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic                       i_clear,
    input  logic                       i_wr_en,
    input  logic                       i_wr_bank,
    input  logic [2:0]                 i_wr_sel,
    input  logic [sbq_pkg::CF_W-1:0]   i_wr_data,
    input  sbq_pkg::t_rec              i_next,
    output sbq_pkg::t_rec              o_rec
);
    sbq_pkg::t_rec r_rec;
    sbq_pkg::t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_shift) begin
            n_rec = i_next;
        end
        if (i_wr_en) begin
            n_rec.coef[i_wr_bank][i_wr_sel] = i_wr_data;
        end
        if (i_clear) begin
            n_rec.zl1 = '0;
            n_rec.zl2 = '0;
            n_rec.zr1 = '0;
            n_rec.zr2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else begin
            r_rec <= n_rec;
        end
    end

    assign o_rec = r_rec;
endmodule

/* hdl/sbq_sect.sv */
// biquad section datapath for one channel, one coefficient product per step
`timescale 1ns / 1ps
module sbq_sect (
    input  logic                                              i_clk,
    input  logic [2:0]                                        i_step,
    input  logic [sbq_pkg::NCOEF-1:0][sbq_pkg::CF_W-1:0]      i_coef,
    input  logic signed [sbq_pkg::DL_W-1:0]                   i_x,
    input  logic signed [sbq_pkg::DL_W-1:0]                   i_z1,
    input  logic signed [sbq_pkg::DL_W-1:0]                   i_z2,
    output logic signed [sbq_pkg::DL_W-1:0]                   o_y,
    output logic signed [sbq_pkg::DL_W-1:0]                   o_z1,
    output logic signed [sbq_pkg::DL_W-1:0]                   o_z2
);
    logic signed [sbq_pkg::CF_W-1:0]  w_c;
    logic signed [sbq_pkg::DL_W-1:0]  w_v;
    logic signed [23:0]               w_vh;
    logic signed [24:0]               w_vl;
    logic signed [55:0]               r_ph;
    logic signed [56:0]               r_pl;
    logic signed [56:0]               w_pls;
    logic signed [56:0]               w_a;
    logic signed [56:0]               w_m;
    logic signed [sbq_pkg::MQ_W-1:0]  r_m;
    logic signed [sbq_pkg::MQ_W-1:0]  r_acc1;
    logic signed [sbq_pkg::MQ_W-1:0]  r_acc2;
    logic signed [sbq_pkg::DL_W-1:0]  r_y;
    logic signed [sbq_pkg::DL_W-1:0]  r_z1;
    logic signed [sbq_pkg::DL_W-1:0]  r_z2;

    // operand pick: b terms use x, a terms use y
    always_comb begin
        case (i_step)
            sbq_pkg::SEL_B0, sbq_pkg::SEL_B1, sbq_pkg::SEL_B2: begin
                w_c = i_coef[i_step];
                w_v = i_x;
            end
            sbq_pkg::SEL_A1, sbq_pkg::SEL_A2: begin
                w_c = i_coef[i_step];
                w_v = r_y;
            end
            default: begin
                w_c = '0;
                w_v = '0;
            end
        endcase
    end

    assign w_vh  = w_v[47:24];
    assign w_vl  = {1'b0, w_v[23:0]};
    assign w_pls = r_pl >>> 24;
    assign w_a   = 57'(r_ph) + w_pls;
    assign w_m   = (w_a + 57'sd8) >>> 4;

    always_ff @(posedge i_clk) begin
        r_ph <= w_c * w_vh;
        r_pl <= w_c * w_vl;
        r_m  <= w_m[sbq_pkg::MQ_W-1:0];
        case (i_step)
            sbq_pkg::STP_Y:    r_y <= sbq_pkg::sat48(56'(r_m) + 56'(i_z1));
            sbq_pkg::STP_ACC1: r_acc1 <= r_m;
            sbq_pkg::STP_ACC2: r_acc2 <= r_m;
            sbq_pkg::STP_Z1:   r_z1 <= sbq_pkg::sat48(56'(r_acc1) - 56'(r_m) + 56'(i_z2));
            sbq_pkg::STP_Z2:   r_z2 <= sbq_pkg::sat48(56'(r_acc2) - 56'(r_m));
            default: ;
        endcase
    end

    assign o_y  = r_y;
    assign o_z1 = r_z1;
    assign o_z2 = r_z2;
endmodule

/* hdl/stereo_biquad_eq_cascade_core.sv */
// top level of the stereo biquad cascade equaliser
`timescale 1ns / 1ps
// Stereo equaliser: each sample pair runs through up to BANDS transposed direct
// form II biquad sections that share one coefficient bank; every section output
// is clamped to +/-8.0 before the next. The bands live in a ring of cells that
// rotates once per band, so cell 0 always holds the band being worked on, and a
// left and a right section unit do the arithmetic one product per clock. For a
// sample pair, each active band takes eight steps set by the product schedule of
// the section units, each idle band takes one rotation, and the finished pair
// then waits for a free output slot. The input takes no beat while a pair is in
// flight; coefficient writes and commits give no output beat. A commit swaps
// banks, sets the band count and zeroes all delay state.
module stereo_biquad_eq_cascade_core #(
    parameter int BANDS = sbq_pkg::BANDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic signed [sbq_pkg::SMP_W-1:0]   i_left_sample,
    input  logic signed [sbq_pkg::SMP_W-1:0]   i_right_sample,
    input  logic [4:0]                         i_band_index,
    input  logic [2:0]                         i_coeff_select,
    input  logic signed [sbq_pkg::CF_W-1:0]    i_coeff_value,
    input  logic [5:0]                         i_new_band_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [sbq_pkg::SMP_W-1:0]   o_left_out,
    output logic signed [sbq_pkg::SMP_W-1:0]   o_right_out,
    output logic                               o_bank_in_use
);
    localparam int CW = $clog2(BANDS + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // control state
    logic                              r_state,   n_state;
    logic [CW-1:0]                     r_band,    n_band;
    logic [2:0]                        r_step,    n_step;
    logic [CW-1:0]                     r_run_n,   n_run_n;
    logic                              r_run_bank, n_run_bank;
    logic                              r_bank,    n_bank;
    logic [1:0][CW-1:0]                r_cnt,     n_cnt;
    logic                              r_out_valid, n_out_valid;
    // payload
    logic signed [sbq_pkg::SMP_W-1:0]  r_xl, n_xl;
    logic signed [sbq_pkg::SMP_W-1:0]  r_xr, n_xr;
    logic signed [sbq_pkg::SMP_W-1:0]  r_out_l, n_out_l;
    logic signed [sbq_pkg::SMP_W-1:0]  r_out_r, n_out_r;
    logic                              r_out_bank, n_out_bank;

    logic                              w_in_acc;
    logic                              w_wr_ok;
    logic                              w_commit;
    logic                              w_active;
    logic                              w_done;
    logic                              w_shift;
    logic [CW-1:0]                     w_cnt_sat;
    sbq_pkg::t_rec                     w_rec  [BANDS];
    sbq_pkg::t_rec                     w_feed [BANDS];
    sbq_pkg::t_rec                     w_head;
    logic signed [sbq_pkg::DL_W-1:0]   w_yl, w_z1l, w_z2l;
    logic signed [sbq_pkg::DL_W-1:0]   w_yr, w_z1r, w_z2r;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_wr_ok    = w_in_acc && (i_cmd == sbq_pkg::CMD_WRITE) &&
                        (i_coeff_select <= sbq_pkg::SEL_A2);
    assign w_commit   = w_in_acc && (i_cmd == sbq_pkg::CMD_COMMIT);
    assign w_active   = (r_state == ST_RUN) && (r_band < r_run_n);
    assign w_done     = (r_state == ST_RUN) && (r_band == CW'(BANDS));
    assign w_shift    = (r_state == ST_RUN) && !w_done &&
                        (!w_active || (r_step == sbq_pkg::STP_LAST));
    assign w_cnt_sat  = (32'(i_new_band_count) > BANDS) ? CW'(BANDS) : CW'(i_new_band_count);

    // head cell with freshly computed delays goes round to the tail
    always_comb begin
        w_head = w_rec[0];
        if (w_active) begin
            w_head.zl1 = w_z1l;
            w_head.zl2 = w_z2l;
            w_head.zr1 = w_z1r;
            w_head.zr2 = w_z2r;
        end
    end

    genvar g;
    generate
        for (g = 0; g < BANDS; g++) begin : g_cell
            if (g == BANDS - 1) begin : g_tail
                assign w_feed[g] = w_head;
            end else begin : g_mid
                assign w_feed[g] = w_rec[g+1];
            end
            sbq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_shift),
                .i_clear   (w_commit),
                .i_wr_en   (w_wr_ok && (32'(i_band_index) == g)),
                .i_wr_bank (~r_bank),
                .i_wr_sel  (i_coeff_select),
                .i_wr_data (i_coeff_value),
                .i_next    (w_feed[g]),
                .o_rec     (w_rec[g])
            );
        end
    endgenerate

    // left and right section units work in lockstep on the head band
    sbq_sect u_sect_l (
        .i_clk  (i_clk),
        .i_step (r_step),
        .i_coef (w_rec[0].coef[r_run_bank]),
        .i_x    (48'(r_xl)),
        .i_z1   (w_rec[0].zl1),
        .i_z2   (w_rec[0].zl2),
        .o_y    (w_yl),
        .o_z1   (w_z1l),
        .o_z2   (w_z2l)
    );

    sbq_sect u_sect_r (
        .i_clk  (i_clk),
        .i_step (r_step),
        .i_coef (w_rec[0].coef[r_run_bank]),
        .i_x    (48'(r_xr)),
        .i_z1   (w_rec[0].zr1),
        .i_z2   (w_rec[0].zr2),
        .o_y    (w_yr),
        .o_z1   (w_z1r),
        .o_z2   (w_z2r)
    );

    always_comb begin
        n_state     = r_state;
        n_band      = r_band;
        n_step      = r_step;
        n_run_n     = r_run_n;
        n_run_bank  = r_run_bank;
        n_bank      = r_bank;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_xl        = r_xl;
        n_xr        = r_xr;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_bank  = r_out_bank;

        if (w_in_acc) begin
            case (i_cmd)
                sbq_pkg::CMD_SAMPLE: begin
                    n_xl       = i_left_sample;
                    n_xr       = i_right_sample;
                    n_run_n    = r_cnt[r_bank];
                    n_run_bank = r_bank;
                    n_band     = '0;
                    n_step     = '0;
                    n_state    = ST_RUN;
                end
                sbq_pkg::CMD_COMMIT: begin
                    n_cnt[~r_bank] = w_cnt_sat;
                    n_bank         = ~r_bank;
                end
                default: ;
            endcase
        end

        if (w_done) begin
            // wait for the output slot, then hand the pair over
            if (!r_out_valid || i_out_ready) begin
                n_out_valid = 1'b1;
                n_out_l     = r_xl;
                n_out_r     = r_xr;
                n_out_bank  = r_run_bank;
                n_band      = '0;
                n_state     = ST_IDLE;
            end
        end else if (w_active) begin
            n_step = r_step + 3'd1;
            if (r_step == sbq_pkg::STP_LAST) begin
                n_xl   = sbq_pkg::clamp8(w_yl);
                n_xr   = sbq_pkg::clamp8(w_yr);
                n_band = r_band + CW'(1);
            end
        end else if (r_state == ST_RUN) begin
            n_band = r_band + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_band      <= '0;
            r_step      <= '0;
            r_run_n     <= '0;
            r_run_bank  <= 1'b0;
            r_bank      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_band      <= n_band;
            r_step      <= n_step;
            r_run_n     <= n_run_n;
            r_run_bank  <= n_run_bank;
            r_bank      <= n_bank;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xl       <= n_xl;
        r_xr       <= n_xr;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
        r_out_bank <= n_out_bank;
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_out_l;
    assign o_right_out   = r_out_r;
    assign o_bank_in_use = r_out_bank;

    // commit leaves the head band with empty delays
    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (w_rec[0].zl1 == '0 && w_rec[0].zr2 == '0))
        else $error("delay state not cleared by commit");

    // a fresh result comes from the bank still active
    a_bank_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_bank_in_use == r_bank))
        else $error("result bank differs from active bank");

    // ring is back home whenever the block is idle
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_band == '0 && r_step == '0))
        else $error("ring not at home position while idle");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_band <= CW'(BANDS))
        else $error("band counter overran");
endmodule

/* test/stereo_biquad_eq_cascade_core_tb.sv */
// self-checking testbench for the stereo biquad cascade equaliser core
`timescale 1ns / 1ps
module stereo_biquad_eq_cascade_core_tb;
    localparam int     NBANDS    = sbq_pkg::BANDS_DEF;
    localparam int     RAND_ITEMS = 1680;
    localparam longint CYC_LIMIT = 4000000;
    localparam longint DLY_MAX   = (longint'(1) <<< 47) - 1;
    localparam longint DLY_MIN   = -(longint'(1) <<< 47);
    localparam longint OUT_POS   = longint'(1) <<< 27;
    localparam longint OUT_NEG   = -(longint'(1) <<< 27);
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic signed [sbq_pkg::CF_W-1:0] COEF_ONE = 32'sh1000_0000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [1:0]                         i_cmd = sbq_pkg::CMD_SAMPLE;
    logic signed [sbq_pkg::SMP_W-1:0]   i_left_sample = '0;
    logic signed [sbq_pkg::SMP_W-1:0]   i_right_sample = '0;
    logic [4:0]                         i_band_index = '0;
    logic [2:0]                         i_coeff_select = '0;
    logic signed [sbq_pkg::CF_W-1:0]    i_coeff_value = '0;
    logic [5:0]                         i_new_band_count = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [sbq_pkg::SMP_W-1:0]   o_left_out;
    logic signed [sbq_pkg::SMP_W-1:0]   o_right_out;
    logic                               o_bank_in_use;

    stereo_biquad_eq_cascade_core u_top (.*);

    always #1 i_clk = ~i_clk;

    // one expected output beat
    typedef struct {
        logic signed [sbq_pkg::SMP_W-1:0] left;
        logic signed [sbq_pkg::SMP_W-1:0] right;
        logic                             bank;
    } t_pair;

    // one directed stimulus row; a typed expectation only where it is obvious
    typedef struct {
        logic [1:0]                       cmd;
        logic signed [sbq_pkg::SMP_W-1:0] left;
        logic signed [sbq_pkg::SMP_W-1:0] right;
        logic [4:0]                       band;
        logic [2:0]                       sel;
        logic signed [sbq_pkg::CF_W-1:0]  coef;
        logic [5:0]                       cnt;
        bit                               typed;
        t_pair                            want;
    } t_row;

    // filter model state
    longint coef_bank [2][NBANDS][sbq_pkg::NCOEF];
    int     band_cnt  [2];
    bit     live_bank;
    longint dly_l [NBANDS][2];
    longint dly_r [NBANDS][2];

    t_pair  pending_pairs [$];
    t_row   rows [$];
    t_row   typed_rows [$];
    int     fail_cnt = 0;
    int     idle_in = 0;
    int     idle_out = 0;
    bit     hold_req = 1'b0;
    longint cyc = 0;

    function automatic longint sat_dly(longint v);
        if (v > DLY_MAX) return DLY_MAX;
        if (v < DLY_MIN) return DLY_MIN;
        return v;
    endfunction

    // coefficient times value, rounded to Q.24 half up
    function automatic longint round_mul(longint c, longint v);
        longint vh, vl, a;
        vh = v >>> 24;
        vl = v - (vh <<< 24);
        a  = c * vh + ((c * vl) >>> 24);
        return (a + 8) >>> 4;
    endfunction

    // one section, delay pair updated in place
    function automatic longint run_section(longint x, int bank, int b, ref longint z [2]);
        longint y;
        y    = sat_dly(round_mul(coef_bank[bank][b][sbq_pkg::SEL_B0], x) + z[0]);
        z[0] = sat_dly(round_mul(coef_bank[bank][b][sbq_pkg::SEL_B1], x)
                       - round_mul(coef_bank[bank][b][sbq_pkg::SEL_A1], y) + z[1]);
        z[1] = sat_dly(round_mul(coef_bank[bank][b][sbq_pkg::SEL_B2], x)
                       - round_mul(coef_bank[bank][b][sbq_pkg::SEL_A2], y));
        if (y > OUT_POS) y = OUT_POS;
        if (y < OUT_NEG) y = OUT_NEG;
        return y;
    endfunction

    function automatic void clear_delays();
        for (int b = 0; b < NBANDS; b++) begin
            dly_l[b] = '{0, 0};
            dly_r[b] = '{0, 0};
        end
    endfunction

    // advance the filter model by one accepted beat; returns 1 with a pair out
    function automatic bit filter_beat(t_row it, output t_pair res);
        longint l, r;
        longint zt [2];
        int     bk;
        res = '{0, 0, 0};
        case (it.cmd)
            sbq_pkg::CMD_SAMPLE: begin
                l  = longint'(it.left);
                r  = longint'(it.right);
                bk = int'(live_bank);
                for (int b = 0; b < band_cnt[bk]; b++) begin
                    zt = dly_l[b]; l = run_section(l, bk, b, zt); dly_l[b] = zt;
                    zt = dly_r[b]; r = run_section(r, bk, b, zt); dly_r[b] = zt;
                end
                res.left  = l[sbq_pkg::SMP_W-1:0];
                res.right = r[sbq_pkg::SMP_W-1:0];
                res.bank  = live_bank;
                return 1'b1;
            end
            sbq_pkg::CMD_WRITE: begin
                if (it.sel <= sbq_pkg::SEL_A2)
                    coef_bank[~live_bank][it.band][it.sel] = longint'(it.coef);
            end
            sbq_pkg::CMD_COMMIT: begin
                band_cnt[~live_bank] = (int'(it.cnt) > NBANDS) ? NBANDS : int'(it.cnt);
                live_bank = ~live_bank;
                clear_delays();
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_row mk(logic [1:0] c, logic signed [sbq_pkg::SMP_W-1:0] l,
                                logic signed [sbq_pkg::SMP_W-1:0] r, logic [4:0] b,
                                logic [2:0] s, logic signed [sbq_pkg::CF_W-1:0] v,
                                logic [5:0] n);
        t_row x;
        x = '{c, l, r, b, s, v, n, 1'b0, '{0, 0, 0}};
        return x;
    endfunction

    function automatic t_row mk_typed(logic signed [sbq_pkg::SMP_W-1:0] l,
                                      logic signed [sbq_pkg::SMP_W-1:0] r,
                                      logic signed [sbq_pkg::SMP_W-1:0] el,
                                      logic signed [sbq_pkg::SMP_W-1:0] er,
                                      logic eb);
        t_row x;
        x = mk(sbq_pkg::CMD_SAMPLE, l, r, '0, '0, '0, '0);
        x.typed = 1'b1;
        x.want  = '{el, er, eb};
        return x;
    endfunction

    // drive one beat: random gaps, then hold valid until taken
    task automatic offer(t_row it);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= it.cmd;
        i_left_sample    <= it.left;
        i_right_sample   <= it.right;
        i_band_index     <= it.band;
        i_coeff_select   <= it.sel;
        i_coeff_value    <= it.coef;
        i_new_band_count <= it.cnt;
        if (it.cmd == sbq_pkg::CMD_SAMPLE) typed_rows.push_back(it);
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [sbq_pkg::SMP_W-1:0] rnd_smp();
        case ($urandom_range(3))
            0: return 29'($urandom);
            1: return 29'($signed(29'($urandom_range(0, 1 << 26))) - (1 << 25));
            2: return 29'($signed(29'($urandom_range(0, 1 << 24))) - (1 << 23));
            default: return 29'($signed(29'($urandom_range(0, 1 << 28))) - (1 << 27));
        endcase
    endfunction

    // mostly tame coefficients so the cascade stays out of saturation
    function automatic logic signed [sbq_pkg::CF_W-1:0] rnd_coef(logic [2:0] s);
        if ($urandom_range(9) == 0) return $urandom;
        if (s == sbq_pkg::SEL_B0)
            return COEF_ONE + $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
        return $signed(32'($urandom_range(0, 1 << 27))) - (1 << 26);
    endfunction

    function automatic t_row rnd_row();
        int     k;
        t_row   x;
        logic [2:0] s;
        k = $urandom_range(99);
        x = mk(sbq_pkg::CMD_SAMPLE, rnd_smp(), rnd_smp(), 5'($urandom), 3'($urandom),
               $urandom, 6'($urandom));
        if (k < 70) begin
            x.cmd = sbq_pkg::CMD_SAMPLE;
        end else if (k < 88) begin
            s     = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
            x.cmd = sbq_pkg::CMD_WRITE;
            x.sel = s;
            x.band = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
            x.coef = rnd_coef(s);
        end else if (k < 95) begin
            x.cmd = sbq_pkg::CMD_COMMIT;
            case ($urandom_range(19))
                0:       x.cnt = 6'(NBANDS);
                1:       x.cnt = 6'($urandom_range(NBANDS + 1, 63));
                2:       x.cnt = 6'($urandom_range(5, NBANDS));
                default: x.cnt = 6'($urandom_range(0, 4));
            endcase
        end else begin
            x.cmd = CMD_SPARE;
        end
        return x;
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = 3000;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_out);
            end
        end
    end

    // monitor: predict on every taken input beat, check every taken output beat
    always @(posedge i_clk) begin
        t_row  it;
        t_row  tr;
        t_pair res;
        t_pair exp_pair;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            it = mk(i_cmd, i_left_sample, i_right_sample, i_band_index, i_coeff_select,
                    i_coeff_value, i_new_band_count);
            if (filter_beat(it, res)) begin
                tr = typed_rows.pop_front();
                pending_pairs.push_back(tr.typed ? tr.want : res);
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("output beat with nothing expected");
                fail_cnt++;
            end else begin
                exp_pair = pending_pairs.pop_front();
                if (o_left_out !== exp_pair.left) begin
                    $error("left_out expected %0d got %0d", exp_pair.left, o_left_out);
                    fail_cnt++;
                end
                if (o_right_out !== exp_pair.right) begin
                    $error("right_out expected %0d got %0d", exp_pair.right, o_right_out);
                    fail_cnt++;
                end
                if (o_bank_in_use !== exp_pair.bank) begin
                    $error("bank_in_use expected %0d got %0d", exp_pair.bank, o_bank_in_use);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int spin;
        for (int k = 0; k < 2; k++) begin
            band_cnt[k] = 0;
            for (int b = 0; b < NBANDS; b++)
                for (int c = 0; c < sbq_pkg::NCOEF; c++) coef_bank[k][b][c] = 0;
        end
        live_bank = 1'b0;
        clear_delays();

        // directed rows: pass-through, ignored commands, saturating count,
        // stale standby data, clamp at plus and minus eight
        rows.push_back(mk_typed(29'sh0FFF_FFFF, -29'sh1000_0000,
                                29'sh0FFF_FFFF, -29'sh1000_0000, 1'b0));
        rows.push_back(mk_typed('0, -29'sd1, '0, -29'sd1, 1'b0));
        rows.push_back(mk(CMD_SPARE, 29'sh0ABC_DEF0, '1, 5'h1F, 3'h7, '1, 6'h3F));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, 3'd5, COEF_ONE, '0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, 3'd7, COEF_ONE, '0));
        rows.push_back(mk_typed(29'sd12345, -29'sd777, 29'sd12345, -29'sd777, 1'b0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd31, sbq_pkg::SEL_A2,
                          32'sh7FFF_FFFF, '0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd31, sbq_pkg::SEL_A2,
                          -32'sh8000_0000, '0));
        rows.push_back(mk(sbq_pkg::CMD_COMMIT, '0, '0, '0, '0, '0, 6'd63));
        // all-zero feed-forward coefficients kill the signal
        rows.push_back(mk_typed(29'sh0123_4567, -29'sh0123_4567, '0, '0, 1'b1));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_B0, COEF_ONE, '0));
        rows.push_back(mk(sbq_pkg::CMD_COMMIT, '0, '0, '0, '0, '0, 6'd0));
        rows.push_back(mk_typed(-29'sh1000_0000, 29'sh0FFF_FFFF,
                                -29'sh1000_0000, 29'sh0FFF_FFFF, 1'b0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_B0, COEF_ONE, '0));
        rows.push_back(mk(sbq_pkg::CMD_COMMIT, '0, '0, '0, '0, '0, 6'd1));
        // unity gain, big input clamps to plus or minus eight
        rows.push_back(mk_typed(29'sh0FFF_FFFF, -29'sh1000_0000, 29'sh0800_0000,
                                -29'sh0800_0000, 1'b1));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_B1,
                          32'sh0800_0000, '0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_B2,
                          -32'sh0400_0000, '0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_A1,
                          32'sh0200_0000, '0));
        rows.push_back(mk(sbq_pkg::CMD_WRITE, '0, '0, 5'd0, sbq_pkg::SEL_A2,
                          -32'sh0100_0000, '0));
        rows.push_back(mk(sbq_pkg::CMD_SAMPLE, 29'sh0100_0000, 29'sh0200_0000,
                          '0, '0, '0, '0));
        // stale standby data: bank 0 still has its old b0
        rows.push_back(mk(sbq_pkg::CMD_COMMIT, '0, '0, '0, '0, '0, 6'd2));
        rows.push_back(mk(sbq_pkg::CMD_SAMPLE, 29'sh0100_0000, -29'sh0300_0000,
                          '0, '0, '0, '0));
        rows.push_back(mk(sbq_pkg::CMD_SAMPLE, 29'sh00AA_5555, 29'sh0055_AAAA,
                          '0, '0, '0, '0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_in  = 32;
        idle_out = 70;
        foreach (rows[k]) offer(rows[k]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                idle_in  = 70;
                idle_out = 32;
            end
            if (n == 2 * RAND_ITEMS / 3) begin
                idle_in  = 0;
                idle_out = 0;
                hold_req = 1'b1;   // long receiver hold-off, sender keeps offering
            end
            offer(rnd_row());
        end
        i_in_valid <= 1'b0;

        spin = 0;
        while (pending_pairs.size() != 0 && spin < 200000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (300) @(posedge i_clk);
        if (pending_pairs.size() != 0) begin
            $error("%0d output beats never arrived", pending_pairs.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/sbq_pkg.sv
hdl/sbq_cell.sv
hdl/sbq_sect.sv
hdl/stereo_biquad_eq_cascade_core.sv
test/stereo_biquad_eq_cascade_core_tb.sv
